// ----- hw/rtl/pbfa_pkg.sv -----
`timescale 1ns / 1ps
// pbfa_pkg: shared constants, codes and packed types of the pixel box filter accumulator
// depends on nothing; every other file but pbfa_ram uses it by scoped names

package pbfa_pkg;

    // pixel store geometry
    localparam int PIXEL_STORE_DEPTH = 65536;
    localparam int ADDR_W            = $clog2(PIXEL_STORE_DEPTH);

    // field widths
    localparam int COORD_W  = 10;
    localparam int WIDTH_W  = 11;
    localparam int ROW_W    = COORD_W + WIDTH_W;
    localparam int IDX_W    = ROW_W + 1;
    localparam int CHAN_W   = 24;
    localparam int SUM_W    = 40;
    localparam int COUNT_W  = 16;
    localparam int NUM_CHAN = 3;

    // 255.0 in unsigned 16.8
    localparam logic [CHAN_W-1:0]  CLAMP_LIMIT = 24'd65280;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = WIDTH_W;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CLAMP_ENABLE = 2'd1;
    localparam logic [WIDTH_W-1:0]     IMAGE_WIDTH_RESET = 11'd256;

    // command queue between front and back
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

    // divider: the quotient never exceeds a channel, so the top of the sum seeds the remainder
    localparam int QUO_W     = CHAN_W;
    localparam int REM_W     = SUM_W - QUO_W;
    localparam int DIV_STEPS = QUO_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    typedef enum logic {
        REQ_ADD  = 1'b0,
        REQ_READ = 1'b1
    } req_kind_t;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_NO_SAMPLES   = 2'd1,
        ST_OUT_OF_RANGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_LOOKUP,
        BK_DIVIDE,
        BK_REPLY
    } back_state_t;

    typedef struct packed {
        req_kind_t           req_type;
        logic [COORD_W-1:0]  pixel_x;
        logic [COORD_W-1:0]  pixel_y;
        logic [CHAN_W-1:0]   red_in;
        logic [CHAN_W-1:0]   green_in;
        logic [CHAN_W-1:0]   blue_in;
    } pbfa_req_t;

    typedef struct packed {
        logic [CHAN_W-1:0]   red_avg;
        logic [CHAN_W-1:0]   green_avg;
        logic [CHAN_W-1:0]   blue_avg;
        logic [COUNT_W-1:0]  sample_total;
        status_t             status;
    } pbfa_res_t;

    // classified request as it travels through the command queue
    typedef struct packed {
        req_kind_t                        kind;
        logic                             in_range;
        logic [ADDR_W-1:0]                addr;
        logic [NUM_CHAN-1:0][CHAN_W-1:0]  chan;
    } pbfa_cmd_t;

    // one pixel entry of the store
    typedef struct packed {
        logic [NUM_CHAN-1:0][SUM_W-1:0]  sum;
        logic [COUNT_W-1:0]              count;
    } pbfa_entry_t;

    localparam int ENTRY_W = $bits(pbfa_entry_t);

endpackage

// ----- hw/rtl/pixel_box_filter_accumulator.sv -----
`timescale 1ns / 1ps
// pixel_box_filter_accumulator: top level of the per-pixel box reconstruction filter
// depends on pbfa_pkg, pbfa_front, pbfa_cmdq and pbfa_back
//
//   channel   handshake       payload                 transaction when
//   request   push / full     req_item (pbfa_req_t)   push && !full
//   result    empty / pop     res_item (pbfa_res_t)   pop && !empty
//   config    cfg_we          cfg_index, cfg_data     cfg_we
//
// an add in the back end is a store read, then sum update and write back
// a read of a pixel with samples is a store read, 24 divider steps, then result load
// after reset a clearing pass zeroes all 65536 entries of the store, one entry a cycle,
// with full held high; configuration writes are taken throughout
// a two-entry command queue lets requests enter while the back end divides or
// while a result waits to be popped

module pixel_box_filter_accumulator (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  pbfa_pkg::pbfa_req_t              req_item,
    output logic                             empty,
    input  logic                             pop,
    output pbfa_pkg::pbfa_res_t              res_item,
    input  logic                             cfg_we,
    input  logic [pbfa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pbfa_pkg::CFG_DATA_W-1:0]  cfg_data
);

    pbfa_pkg::pbfa_cmd_t new_cmd;
    pbfa_pkg::pbfa_cmd_t head_cmd;
    logic                cmdq_full;
    logic                cmdq_empty;
    logic                cmdq_pop;
    logic                clearing;

    // request side stalls while the queue is full or the store is being cleared
    assign full = cmdq_full || clearing;

    pbfa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_item  (req_item),
        .cmd       (new_cmd)
    );

    pbfa_cmdq u_cmdq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push && !full),
        .wr_cmd  (new_cmd),
        .rd_en   (cmdq_pop),
        .rd_cmd  (head_cmd),
        .q_full  (cmdq_full),
        .q_empty (cmdq_empty)
    );

    pbfa_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmdq_empty (cmdq_empty),
        .head_cmd   (head_cmd),
        .cmdq_pop   (cmdq_pop),
        .clearing   (clearing),
        .empty      (empty),
        .pop        (pop),
        .res_item   (res_item)
    );

endmodule

// ----- hw/rtl/pbfa_ram.sv -----
`timescale 1ns / 1ps
// pbfa_ram: generic simple dual port ram, one write port, one registered read port
// depends on nothing

module pbfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/pbfa_front.sv -----
`timescale 1ns / 1ps
// pbfa_front: configuration registers and request classification
// depends on pbfa_pkg; feeds the command queue

module pbfa_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [pbfa_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [pbfa_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  pbfa_pkg::pbfa_req_t                  req_item,
    output pbfa_pkg::pbfa_cmd_t                  cmd
);

    logic [pbfa_pkg::WIDTH_W-1:0] image_width_reg, image_width_next;
    logic                         clamp_enable_reg, clamp_enable_next;
    logic [pbfa_pkg::ROW_W-1:0]   row_base;
    logic [pbfa_pkg::IDX_W-1:0]   pixel_idx;
    logic [pbfa_pkg::NUM_CHAN-1:0][pbfa_pkg::CHAN_W-1:0] raw_chan;

    // register writes
    always_comb
    begin
        image_width_next  = image_width_reg;
        clamp_enable_next = clamp_enable_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                pbfa_pkg::REG_IMAGE_WIDTH:  image_width_next  = cfg_data;
                pbfa_pkg::REG_CLAMP_ENABLE: clamp_enable_next = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= pbfa_pkg::IMAGE_WIDTH_RESET;
            clamp_enable_reg <= 1'b1;
        end
        else
        begin
            image_width_reg  <= image_width_next;
            clamp_enable_reg <= clamp_enable_next;
        end
    end

    // linear pixel index and range check
    assign row_base  = pbfa_pkg::ROW_W'(req_item.pixel_y) * pbfa_pkg::ROW_W'(image_width_reg);
    assign pixel_idx = pbfa_pkg::IDX_W'(row_base) + pbfa_pkg::IDX_W'(req_item.pixel_x);

    assign raw_chan[0] = req_item.red_in;
    assign raw_chan[1] = req_item.green_in;
    assign raw_chan[2] = req_item.blue_in;

    // command build, with optional saturation at 255.0
    always_comb
    begin
        cmd.kind     = req_item.req_type;
        cmd.in_range = pixel_idx < pbfa_pkg::IDX_W'(pbfa_pkg::PIXEL_STORE_DEPTH);
        cmd.addr     = pixel_idx[pbfa_pkg::ADDR_W-1:0];
        for (int c = 0; c < pbfa_pkg::NUM_CHAN; c++)
        begin
            if (clamp_enable_reg && (raw_chan[c] > pbfa_pkg::CLAMP_LIMIT))
            begin
                cmd.chan[c] = pbfa_pkg::CLAMP_LIMIT;
            end
            else
            begin
                cmd.chan[c] = raw_chan[c];
            end
        end
    end

endmodule

// ----- hw/rtl/pbfa_cmdq.sv -----
`timescale 1ns / 1ps
// pbfa_cmdq: short command queue that decouples the front from the back
// depends on pbfa_pkg

module pbfa_cmdq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  pbfa_pkg::pbfa_cmd_t  wr_cmd,
    input  logic                 rd_en,
    output pbfa_pkg::pbfa_cmd_t  rd_cmd,
    output logic                 q_full,
    output logic                 q_empty
);

    pbfa_pkg::pbfa_cmd_t               slot_reg [pbfa_pkg::CMDQ_DEPTH];
    logic [pbfa_pkg::CMDQ_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [pbfa_pkg::CMDQ_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [pbfa_pkg::CMDQ_PTR_W:0]     count_reg, count_next;

    assign q_full  = count_reg == (pbfa_pkg::CMDQ_PTR_W + 1)'(pbfa_pkg::CMDQ_DEPTH);
    assign q_empty = count_reg == '0;
    assign rd_cmd  = slot_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == pbfa_pkg::CMDQ_PTR_W'(pbfa_pkg::CMDQ_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == pbfa_pkg::CMDQ_PTR_W'(pbfa_pkg::CMDQ_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

// ----- hw/rtl/pbfa_div.sv -----
`timescale 1ns / 1ps
// pbfa_div: three-lane restoring divider, one quotient bit per lane per cycle
// depends on pbfa_pkg; used by the back end for the channel averages

module pbfa_div (
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  logic                                               start,
    input  logic [pbfa_pkg::NUM_CHAN-1:0][pbfa_pkg::SUM_W-1:0] dividend,
    input  logic [pbfa_pkg::COUNT_W-1:0]                       divisor,
    output logic                                               done,
    output logic [pbfa_pkg::NUM_CHAN-1:0][pbfa_pkg::QUO_W-1:0] quotient
);

    logic                                               busy_reg, busy_next;
    logic                                               done_reg, done_next;
    logic [pbfa_pkg::DIV_CNT_W-1:0]                     step_reg, step_next;
    logic [pbfa_pkg::COUNT_W-1:0]                       divisor_reg, divisor_next;
    logic [pbfa_pkg::NUM_CHAN-1:0][pbfa_pkg::REM_W-1:0] rem_reg, rem_next;
    logic [pbfa_pkg::NUM_CHAN-1:0][pbfa_pkg::QUO_W-1:0] quo_reg, quo_next;
    logic [pbfa_pkg::REM_W:0]                           shifted;
    logic [pbfa_pkg::REM_W:0]                           divisor_ext;
    logic                                               fits;

    assign divisor_ext = (pbfa_pkg::REM_W + 1)'(divisor_reg);

    // seed from the top of the sum, then shift-subtract one bit a cycle
    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        step_next    = step_reg;
        divisor_next = divisor_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        shifted      = '0;
        fits         = 1'b0;
        if (start)
        begin
            busy_next    = 1'b1;
            step_next    = '0;
            divisor_next = divisor;
            for (int c = 0; c < pbfa_pkg::NUM_CHAN; c++)
            begin
                rem_next[c] = dividend[c][pbfa_pkg::SUM_W-1:pbfa_pkg::QUO_W];
                quo_next[c] = dividend[c][pbfa_pkg::QUO_W-1:0];
            end
        end
        else if (busy_reg)
        begin
            for (int c = 0; c < pbfa_pkg::NUM_CHAN; c++)
            begin
                shifted     = {rem_reg[c], quo_reg[c][pbfa_pkg::QUO_W-1]};
                fits        = shifted >= divisor_ext;
                rem_next[c] = fits ? pbfa_pkg::REM_W'(shifted - divisor_ext)
                                   : shifted[pbfa_pkg::REM_W-1:0];
                quo_next[c] = {quo_reg[c][pbfa_pkg::QUO_W-2:0], fits};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == pbfa_pkg::DIV_CNT_W'(pbfa_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // lane datapath
    always_ff @(posedge clk)
    begin
        divisor_reg <= divisor_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- hw/rtl/pbfa_back.sv -----
`timescale 1ns / 1ps
// pbfa_back: pixel store, read-modify-write of sums, averaging and result register
// depends on pbfa_pkg, pbfa_ram and pbfa_div

module pbfa_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmdq_empty,
    input  pbfa_pkg::pbfa_cmd_t  head_cmd,
    output logic                 cmdq_pop,
    output logic                 clearing,
    output logic                 empty,
    input  logic                 pop,
    output pbfa_pkg::pbfa_res_t  res_item
);

    pbfa_pkg::back_state_t                              state_reg, state_next;
    logic [pbfa_pkg::ADDR_W-1:0]                        clear_addr_reg, clear_addr_next;
    pbfa_pkg::pbfa_cmd_t                                cmd_reg, cmd_next;
    pbfa_pkg::pbfa_res_t                                res_reg, res_next;
    pbfa_pkg::pbfa_res_t                                out_reg, out_next;
    logic                                               out_valid_reg, out_valid_next;

    logic                                               ram_we;
    logic [pbfa_pkg::ADDR_W-1:0]                        ram_waddr;
    logic [pbfa_pkg::ENTRY_W-1:0]                       ram_wdata;
    logic [pbfa_pkg::ENTRY_W-1:0]                       ram_rdata;
    pbfa_pkg::pbfa_entry_t                              rd_entry;
    pbfa_pkg::pbfa_entry_t                              upd_entry;

    logic                                               div_start;
    logic                                               div_done;
    logic [pbfa_pkg::NUM_CHAN-1:0][pbfa_pkg::QUO_W-1:0] div_quo;

    pbfa_ram #(
        .WIDTH (pbfa_pkg::ENTRY_W),
        .DEPTH (pbfa_pkg::PIXEL_STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (head_cmd.addr),
        .rdata (ram_rdata)
    );

    pbfa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rd_entry.sum),
        .divisor  (rd_entry.count),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign rd_entry = pbfa_pkg::pbfa_entry_t'(ram_rdata);

    // accumulated entry for an add
    always_comb
    begin
        for (int c = 0; c < pbfa_pkg::NUM_CHAN; c++)
        begin
            upd_entry.sum[c] = rd_entry.sum[c] + pbfa_pkg::SUM_W'(cmd_reg.chan[c]);
        end
        upd_entry.count = rd_entry.count + 1'b1;
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        clear_addr_next = clear_addr_reg;
        cmd_next        = cmd_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        cmdq_pop        = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = cmd_reg.addr;
        ram_wdata       = upd_entry;
        div_start       = 1'b0;

        // result taken by the consumer
        if (out_valid_reg && pop)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            pbfa_pkg::BK_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clear_addr_reg;
                ram_wdata = '0;
                if (clear_addr_reg == pbfa_pkg::ADDR_W'(pbfa_pkg::PIXEL_STORE_DEPTH - 1))
                begin
                    state_next = pbfa_pkg::BK_IDLE;
                end
                else
                begin
                    clear_addr_next = clear_addr_reg + 1'b1;
                end
            end

            pbfa_pkg::BK_IDLE:
            begin
                if (!cmdq_empty)
                begin
                    cmdq_pop = 1'b1;
                    cmd_next = head_cmd;
                    if (head_cmd.in_range)
                    begin
                        state_next = pbfa_pkg::BK_LOOKUP;
                    end
                    else if (head_cmd.kind == pbfa_pkg::REQ_READ)
                    begin
                        res_next        = '0;
                        res_next.status = pbfa_pkg::ST_OUT_OF_RANGE;
                        state_next      = pbfa_pkg::BK_REPLY;
                    end
                end
            end

            pbfa_pkg::BK_LOOKUP:
            begin
                if (cmd_reg.kind == pbfa_pkg::REQ_ADD)
                begin
                    ram_we     = rd_entry.count != pbfa_pkg::COUNT_MAX;
                    state_next = pbfa_pkg::BK_IDLE;
                end
                else if (rd_entry.count == '0)
                begin
                    res_next        = '0;
                    res_next.status = pbfa_pkg::ST_NO_SAMPLES;
                    state_next      = pbfa_pkg::BK_REPLY;
                end
                else
                begin
                    div_start             = 1'b1;
                    res_next.sample_total = rd_entry.count;
                    res_next.status       = pbfa_pkg::ST_OK;
                    state_next            = pbfa_pkg::BK_DIVIDE;
                end
            end

            pbfa_pkg::BK_DIVIDE:
            begin
                if (div_done)
                begin
                    res_next.red_avg   = div_quo[0];
                    res_next.green_avg = div_quo[1];
                    res_next.blue_avg  = div_quo[2];
                    state_next         = pbfa_pkg::BK_REPLY;
                end
            end

            pbfa_pkg::BK_REPLY:
            begin
                if (!out_valid_next)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = pbfa_pkg::BK_IDLE;
                end
            end

            default:
            begin
                state_next = pbfa_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pbfa_pkg::BK_CLEAR;
            clear_addr_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clear_addr_reg <= clear_addr_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    assign clearing = state_reg == pbfa_pkg::BK_CLEAR;
    assign empty    = !out_valid_reg;
    assign res_item = out_reg;

endmodule

// ----- hw/rtl/pbfa_checker.sv -----
`timescale 1ns / 1ps
// pbfa_checker: port-level checks of the pixel box filter accumulator, with its bind
// depends on pbfa_pkg and the top level pixel_box_filter_accumulator

module pbfa_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             full,
    input  logic                             empty,
    input  logic                             pop,
    input  pbfa_pkg::pbfa_res_t              res_item
);

    // a good average always comes with at least one sample
    a_ok_has_samples: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (res_item.status == pbfa_pkg::ST_OK)) |-> (res_item.sample_total != '0))
        else $error("ok result with zero sample total");

    // empty or out-of-range pixels report all zeros
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (res_item.status != pbfa_pkg::ST_OK)) |->
        ((res_item.red_avg == '0) && (res_item.green_avg == '0) &&
         (res_item.blue_avg == '0) && (res_item.sample_total == '0)))
        else $error("fault result carries nonzero fields");

    // the clearing pass blocks requests right after reset
    a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> full)
        else $error("request side open before store clear");

    // a waiting result holds until popped
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(res_item)))
        else $error("waiting result changed or vanished");

endmodule

bind pixel_box_filter_accumulator pbfa_checker u_pbfa_checker (.*);
